### rtl/jmi_pkg.sv
// Shared types and constants of the joint motion interpolator.
package jmi_pkg;

  localparam int MAX_MOTIONS = 16;
  localparam int JOINT_COUNT = 12;
  localparam int POS_W       = 32;
  localparam int TICK_W      = 32;
  localparam int SLOT_W      = 4;
  localparam int FIELD_W     = 4;
  localparam int JOINT_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int DELAY_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY  = 2'd1;

  localparam logic [COUNT_W-1:0] MOTION_COUNT_RST = 5'd1;
  localparam logic [DELAY_W-1:0] START_DELAY_RST  = 16'd500;

  localparam logic REQ_TABLE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [SLOT_W-1:0]       motion_slot;
    logic [FIELD_W-1:0]      table_field;
    logic signed [POS_W-1:0] table_value;
    logic [JOINT_W-1:0]      joint_index;
    logic signed [POS_W-1:0] measured_position;
  } in_t;

  typedef struct packed {
    logic [JOINT_W-1:0]      out_joint;
    logic signed [POS_W-1:0] command_position;
    logic [SLOT_W-1:0]       current_motion;
    logic                    moving;
    logic                    sequence_done;
  } out_t;

  typedef struct packed {
    logic capture;
    logic tbl_wr;
    logic tick_inc;
    logic enter0;
    logic adv;
    logic latch;
    logic ram_rd;
    logic div_start;
    logic upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic joint_ok;
    logic joint_zero;
    logic div_needed;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/jmi_ram.sv
// Generic single-port-write RAM with a registered read.
module jmi_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/jmi_div.sv
// Restoring divider, one quotient bit per cycle, with signed saturation.
module jmi_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [jmi_pkg::POS_W:0]   mag_i,
  input  logic                  neg_i,
  input  logic [jmi_pkg::TICK_W-1:0] den_i,
  output logic                  done_o,
  output logic [jmi_pkg::POS_W-1:0] quo_o
);
  import jmi_pkg::*;

  localparam int NBits = POS_W + 1;
  localparam int CntW  = $clog2(NBits + 1);

  logic              busy_q, done_q, neg_q;
  logic [CntW-1:0]   cnt_q;
  logic [POS_W:0]    a_q;
  logic [TICK_W-1:0] r_q, den_q;
  logic [TICK_W:0]   sh;
  logic              fit;
  logic [POS_W:0]    max_pos, max_neg;

  assign sh  = {r_q, a_q[POS_W]};
  assign fit = (sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= mag_i;
      r_q   <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      r_q <= fit ? TICK_W'(sh - {1'b0, den_q}) : sh[TICK_W-1:0];
      a_q <= {a_q[POS_W-1:0], fit};
    end
  end

  assign max_pos = {2'b00, {(POS_W-1){1'b1}}};
  assign max_neg = {2'b01, {(POS_W-1){1'b0}}};

  always_comb begin
    if (neg_q) begin
      quo_o = (a_q > max_neg) ? {1'b1, {(POS_W-1){1'b0}}} : POS_W'(-a_q);
    end else begin
      quo_o = (a_q > max_pos) ? {1'b0, {(POS_W-1){1'b1}}} : a_q[POS_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

### rtl/jmi_dp.sv
// Datapath: motion tables, tick and motion state, joint commands and output register.
module jmi_dp #(
  parameter int MaxMotions = jmi_pkg::MAX_MOTIONS,
  parameter int JointCount = jmi_pkg::JOINT_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jmi_pkg::in_t                  in_i,
  input  logic                          cfg_we_i,
  input  logic [jmi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [jmi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  jmi_pkg::cmd_t                 cmd_i,
  output jmi_pkg::sts_t                 sts_o,
  output jmi_pkg::out_t                 out_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);
  import jmi_pkg::*;

  localparam int MIdxW = (MaxMotions > 1) ? $clog2(MaxMotions) : 1;
  localparam int JIdxW = (JointCount > 1) ? $clog2(JointCount) : 1;
  localparam int RamD  = MaxMotions * JointCount;
  localparam int RamAw = (RamD > 1) ? $clog2(RamD) : 1;

  logic [COUNT_W-1:0] mc_q;
  logic [DELAY_W-1:0] sd_q;
  logic [TICK_W-1:0]  dur_q [MaxMotions];
  logic [TICK_W-1:0]  pau_q [MaxMotions];

  logic [JOINT_W-1:0] joint_q;
  logic [POS_W-1:0]   meas_q;
  logic [TICK_W-1:0]  tick_q, begin_q, end_q, span_q;
  logic [SLOT_W-1:0]  idx_q;
  logic               done_q, wait_q, mov_q, first_q;
  logic [POS_W-1:0]   cmd_pos_q [JointCount];
  logic [POS_W-1:0]   delta_q [JointCount];
  logic               out_valid_q;
  out_t               out_q;

  logic [SLOT_W-1:0]  last, idx_p1;
  logic [MIdxW-1:0]   taddr;
  logic [TICK_W-1:0]  dur_rd, pau_rd, sd32, limit, tm1;
  logic [JIdxW-1:0]   jsel;
  logic               slot_ok, ram_we, active;
  logic [RamAw-1:0]   waddr, raddr;
  logic [POS_W-1:0]   tgt;
  logic [POS_W:0]     diff, mag;
  logic               div_done;
  logic [POS_W-1:0]   div_q, q_sel;

  assign sd32   = {{(TICK_W-DELAY_W){1'b0}}, sd_q};
  assign idx_p1 = idx_q + 1'b1;
  assign tm1    = tick_q - 1'b1;
  assign jsel   = joint_q[JIdxW-1:0];
  assign active = !wait_q && mov_q;

  always_comb begin
    if (mc_q == '0) begin
      last = '0;
    end else if (int'(mc_q) > MaxMotions) begin
      last = SLOT_W'(MaxMotions - 1);
    end else begin
      last = SLOT_W'(mc_q - 1'b1);
    end
  end

  always_comb begin
    if (cmd_i.enter0) begin
      taddr = '0;
    end else if (cmd_i.adv) begin
      taddr = idx_p1[MIdxW-1:0];
    end else begin
      taddr = idx_q[MIdxW-1:0];
    end
  end
  assign dur_rd = dur_q[taddr];
  assign pau_rd = pau_q[taddr];
  assign limit  = end_q - pau_rd;

  assign slot_ok = int'(in_i.motion_slot) < MaxMotions;
  assign ram_we  = cmd_i.tbl_wr && slot_ok && (int'(in_i.table_field) < JointCount);
  assign waddr   = RamAw'(int'(in_i.motion_slot) * JointCount + int'(in_i.table_field));
  assign raddr   = RamAw'(int'(idx_q) * JointCount + int'(joint_q));

  jmi_ram #(
    .Width(POS_W),
    .Depth(RamD)
  ) u_target_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(in_i.table_value),
    .re_i   (cmd_i.ram_rd),
    .raddr_i(raddr),
    .rdata_o(tgt)
  );

  assign diff = {tgt[POS_W-1], tgt} - {meas_q[POS_W-1], meas_q};
  assign mag  = diff[POS_W] ? -diff : diff;

  jmi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .mag_i  (mag),
    .neg_i  (diff[POS_W]),
    .den_i  (span_q),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  assign q_sel = (span_q == '0) ? '0 : div_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && slot_ok) begin
      if (int'(in_i.table_field) == JointCount) begin
        dur_q[in_i.motion_slot[MIdxW-1:0]] <= in_i.table_value;
      end
      if (int'(in_i.table_field) == JointCount + 1) begin
        pau_q[in_i.motion_slot[MIdxW-1:0]] <= in_i.table_value;
      end
    end
    if (cmd_i.capture) begin
      joint_q <= in_i.joint_index;
      meas_q  <= in_i.measured_position;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q    <= MOTION_COUNT_RST;
      sd_q    <= START_DELAY_RST;
      tick_q  <= '0;
      begin_q <= '0;
      end_q   <= '0;
      span_q  <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
      wait_q  <= 1'b1;
      mov_q   <= 1'b0;
      first_q <= 1'b0;
      for (int j = 0; j < JointCount; j++) begin
        cmd_pos_q[j] <= '0;
        delta_q[j]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MOTION_COUNT: mc_q <= cfg_data_i[COUNT_W-1:0];
          CFG_START_DELAY:  sd_q <= cfg_data_i[DELAY_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.tick_inc) begin
        tick_q <= tick_q + 1'b1;
      end
      if (cmd_i.enter0 && tick_q == TICK_W'(1)) begin
        idx_q   <= '0;
        begin_q <= sd32;
        end_q   <= sd32 + dur_rd + pau_rd;
      end
      if (cmd_i.adv && tick_q >= sd32 && tick_q > end_q && idx_q < last) begin
        idx_q   <= idx_p1;
        begin_q <= tm1;
        end_q   <= tm1 + dur_rd + pau_rd;
      end
      if (cmd_i.latch) begin
        if (tick_q < sd32) begin
          wait_q  <= 1'b1;
          mov_q   <= 1'b0;
          first_q <= 1'b0;
        end else begin
          wait_q  <= 1'b0;
          mov_q   <= (tick_q > begin_q) && (tick_q <= limit);
          first_q <= (tick_q > begin_q) && (tick_q <= limit) && (tick_q == begin_q + 1'b1);
          span_q  <= limit - begin_q;
          if (idx_q >= last) begin
            done_q <= 1'b1;
          end
        end
      end
      if (cmd_i.upd && active) begin
        if (first_q) begin
          cmd_pos_q[jsel] <= meas_q + q_sel;
          delta_q[jsel]   <= q_sel;
        end else begin
          cmd_pos_q[jsel] <= cmd_pos_q[jsel] + delta_q[jsel];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_joint        <= joint_q;
      out_q.command_position <= cmd_pos_q[jsel];
      out_q.current_motion   <= idx_q;
      out_q.moving           <= active;
      out_q.sequence_done    <= done_q;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  assign sts_o.is_sample  = (in_i.req_type == REQ_SAMPLE);
  assign sts_o.joint_ok   = int'(in_i.joint_index) < JointCount;
  assign sts_o.joint_zero = (in_i.joint_index == '0);
  assign sts_o.div_needed = active && first_q && (span_q != '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

### rtl/jmi_ctrl.sv
// Controller state machine sequencing one beat through the datapath.
module jmi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  jmi_pkg::sts_t sts_i,
  output jmi_pkg::cmd_t cmd_o
);
  import jmi_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_ENTER = 4'd2;
  localparam logic [3:0] S_ADV   = 4'd3;
  localparam logic [3:0] S_LATCH = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CALC  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!sts_i.is_sample) begin
            cmd_o.tbl_wr = 1'b1;
          end else if (sts_i.joint_ok) begin
            state_d = sts_i.joint_zero ? S_TICK : S_RD;
          end
        end
      end
      S_TICK: begin
        cmd_o.tick_inc = 1'b1;
        state_d = S_ENTER;
      end
      S_ENTER: begin
        cmd_o.enter0 = 1'b1;
        state_d = S_ADV;
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        state_d = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.latch = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        cmd_o.ram_rd = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        if (sts_i.div_needed) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_UPD;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/joint_motion_interpolator_unit.sv
// Top level: one in-range joint sample gives one command beat.
// A table write is absorbed in the cycle it is accepted and gives no result.
// A sample for a joint other than 0 runs S_RD, S_CALC, S_UPD, S_OUT; input stalls meanwhile.
// A joint 0 sample first passes S_TICK, S_ENTER, S_ADV, S_LATCH for tick and motion state.
// On a motion's first moving tick each joint also waits in S_DIV for the serial divider.
// Reset clears all control state, commands and deltas; table contents stay undefined.
module joint_motion_interpolator_unit #(
  parameter int MaxMotions = jmi_pkg::MAX_MOTIONS,
  parameter int JointCount = jmi_pkg::JOINT_COUNT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  jmi_pkg::in_t                   in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output jmi_pkg::out_t                  out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [jmi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jmi_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import jmi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  jmi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  jmi_dp #(
    .MaxMotions(MaxMotions),
    .JointCount(JointCount)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

`ifndef SYNTHESIS
  a_table_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_i.req_type == REQ_TABLE |=> !in_stall_o)
    else $error("table write left the block busy");

  a_bad_joint_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_i.req_type == REQ_SAMPLE &&
    int'(in_i.joint_index) >= JointCount |=> !in_stall_o)
    else $error("out-of-range joint sample was processed");

  a_out_joint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_o.out_joint) < JointCount)
    else $error("result beat carries an out-of-range joint");
`endif

endmodule
